/* sv/multiband_audio_compressor_defines.svh */
// Assertion macros shared by the compressor RTL.
`ifndef MULTIBAND_AUDIO_COMPRESSOR_DEFINES_SVH
`define MULTIBAND_AUDIO_COMPRESSOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, disabled while arst_n is low.
`define MBC_ASSERT_IMP(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
	else $error(msg);

// Next-cycle implication, sampled on clk, disabled while arst_n is low.
`define MBC_ASSERT_NXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
	else $error(msg);

`endif

/* sv/mbc_pkg.sv */
package mbc_pkg;

	localparam int NumBands   = 4;
	localparam int SampleBits = 24;
	localparam int NumXo      = NumBands - 1;
	localparam int HistDepth  = NumXo * 16;
	localparam int HistAw     = $clog2(HistDepth);
	localparam int NumRegs    = 8;
	localparam int InW        = ((SampleBits + 7) / 8) * 8;
	localparam int OutW       = ((SampleBits + 128 + 7) / 8) * 8;

	localparam logic signed [15:0] EnvReset   = -16'sd15360;
	localparam logic signed [15:0] LevelFloor = -16'sd28253;
	localparam logic [17:0]        DbPerOct   = 18'd217727;
	localparam logic [13:0]        OctPerDb   = 14'd10885;

	typedef enum logic [2:0] {
		REG_THRESH,
		REG_SLOPE,
		REG_ATTACK,
		REG_RELEASE,
		REG_MAKEUP,
		REG_XO_LOW,
		REG_XO_MID,
		REG_XO_HIGH
	} reg_idx_t;

	typedef enum logic [2:0] {
		T_IDLE,
		T_FILT,
		T_BAND,
		T_BWAIT,
		T_FIN
	} top_state_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_RD,
		F_RDW,
		F_MUL,
		F_ACC,
		F_WR,
		F_DONE
	} flt_state_t;

	typedef enum logic [4:0] {
		B_IDLE,
		B_NORM,
		B_SQ,
		B_SQ2,
		B_LOG,
		B_LVL,
		B_ENV,
		B_ENV2,
		B_GR,
		B_GR2,
		B_EXP,
		B_EXP2,
		B_INT,
		B_MANT,
		B_MUL,
		B_SHF,
		B_DONE
	} band_state_t;

	typedef struct packed {
		logic signed [15:0] th;
		logic [15:0]        slope;
		logic [15:0]        att;
		logic [15:0]        rel;
		logic signed [15:0] makeup;
	} band_cfg_t;

	typedef struct packed {
		logic               done;
		logic signed [15:0] env;
		logic signed [15:0] gr;
		logic signed [47:0] contrib;
	} band_res_t;

	function automatic logic [16:0] exp2_tab(input logic [4:0] i);
		logic [16:0] v;
		unique case (i)
			5'd0:  v = 17'd32768;
			5'd1:  v = 17'd34219;
			5'd2:  v = 17'd35734;
			5'd3:  v = 17'd37316;
			5'd4:  v = 17'd38968;
			5'd5:  v = 17'd40693;
			5'd6:  v = 17'd42495;
			5'd7:  v = 17'd44376;
			5'd8:  v = 17'd46341;
			5'd9:  v = 17'd48393;
			5'd10: v = 17'd50535;
			5'd11: v = 17'd52773;
			5'd12: v = 17'd55109;
			5'd13: v = 17'd57549;
			5'd14: v = 17'd60097;
			5'd15: v = 17'd62757;
			default: v = 17'd65536;
		endcase
		return v;
	endfunction

endpackage

/* sv/mbc_ram.sv */
module mbc_ram #(
	parameter int Depth = 16,
	parameter int Width = 32,
	localparam int Aw = $clog2(Depth)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [Aw-1:0]    waddr,
	input  logic [Width-1:0] wdata,
	input  logic             re,
	input  logic [Aw-1:0]    raddr,
	output logic [Width-1:0] rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* sv/mbc_filter.sv */
module mbc_filter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] x_in,
	input  logic [63:0]        xo_coef [mbc_pkg::NumXo],
	output logic               done,
	output logic signed [31:0] bands [mbc_pkg::NumBands]
);

	mbc_pkg::flt_state_t state_q, state_d;
	logic [1:0] xo_q, bq_q, k_q;
	logic signed [31:0] carry_q, y_q;
	logic signed [31:0] hist_q [4];
	logic signed [50:0] prod_s1;
	logic signed [53:0] acc_q;
	logic               rd_vld_s1, rv_s1;
	logic [1:0]         rd_k_s1;
	logic               hvld_q [mbc_pkg::HistDepth];
	logic signed [31:0] bands_q [mbc_pkg::NumBands];

	logic [63:0]        coef;
	logic signed [15:0] gain;
	logic signed [31:0] xin;
	logic signed [34:0] x35, h0x2, h1_35, tap_sum;
	logic signed [34:0] mul_a;
	logic signed [15:0] mul_b;
	logic signed [50:0] prod;
	logic signed [53:0] y_sh;
	logic signed [31:0] ysat;
	logic [5:0]         addr6;
	logic [mbc_pkg::HistAw-1:0] haddr;
	logic               ren, wen;
	logic [31:0]        wdata, rdata;

	assign coef  = xo_coef[xo_q];
	assign gain  = bq_q[1] ? coef[31:16] : coef[15:0];
	assign xin   = bq_q[0] ? y_q : carry_q;
	assign x35   = 35'(xin);
	assign h0x2  = {{2{hist_q[0][31]}}, hist_q[0], 1'b0};
	assign h1_35 = 35'(hist_q[1]);
	assign tap_sum = bq_q[1] ? (x35 - h0x2 + h1_35) : (x35 + h0x2 + h1_35);
	assign prod  = mul_a * mul_b;
	assign y_sh  = acc_q >>> 14;
	assign ysat  = (y_sh > 54'sd2147483647) ? 32'sh7FFFFFFF :
		(y_sh < -54'sd2147483648) ? 32'sh80000000 : y_sh[31:0];
	assign addr6 = {xo_q, bq_q, k_q};
	assign haddr = addr6[mbc_pkg::HistAw-1:0];

	always_comb begin
		case (k_q)
			2'd0: begin
				mul_a = tap_sum;
				mul_b = gain;
			end
			2'd1: begin
				mul_a = 35'(hist_q[2]);
				mul_b = coef[47:32];
			end
			default: begin
				mul_a = 35'(hist_q[3]);
				mul_b = coef[63:48];
			end
		endcase
		case (k_q)
			2'd0:    wdata = xin;
			2'd1:    wdata = hist_q[0];
			2'd2:    wdata = y_q;
			default: wdata = hist_q[2];
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mbc_pkg::F_IDLE: if (start) state_d = mbc_pkg::F_RD;
			mbc_pkg::F_RD:   if (k_q == 2'd3) state_d = mbc_pkg::F_RDW;
			mbc_pkg::F_RDW:  state_d = mbc_pkg::F_MUL;
			mbc_pkg::F_MUL:  if (k_q == 2'd2) state_d = mbc_pkg::F_ACC;
			mbc_pkg::F_ACC:  state_d = mbc_pkg::F_WR;
			mbc_pkg::F_WR: begin
				if (k_q == 2'd3) begin
					if (bq_q == 2'd3 && 32'(xo_q) == mbc_pkg::NumXo - 1) begin
						state_d = mbc_pkg::F_DONE;
					end else begin
						state_d = mbc_pkg::F_RD;
					end
				end
			end
			mbc_pkg::F_DONE: state_d = mbc_pkg::F_IDLE;
			default:         state_d = mbc_pkg::F_IDLE;
		endcase
	end

	always_comb begin
		ren  = 1'b0;
		wen  = 1'b0;
		done = 1'b0;
		unique case (state_q)
			mbc_pkg::F_RD:   ren = 1'b1;
			mbc_pkg::F_WR:   wen = 1'b1;
			mbc_pkg::F_DONE: done = 1'b1;
			default: begin
			end
		endcase
	end

	mbc_ram #(
		.Depth(mbc_pkg::HistDepth),
		.Width(32)
	) u_hist (
		.clk  (clk),
		.we   (wen),
		.waddr(haddr),
		.wdata(wdata),
		.re   (ren),
		.raddr(haddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= mbc_pkg::F_IDLE;
			k_q       <= '0;
			bq_q      <= '0;
			xo_q      <= '0;
			rd_vld_s1 <= 1'b0;
			for (int i = 0; i < mbc_pkg::HistDepth; i++) begin
				hvld_q[i] <= 1'b0;
			end
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= ren;
			if (state_q != state_d) begin
				k_q <= '0;
			end else if (state_q == mbc_pkg::F_RD || state_q == mbc_pkg::F_MUL ||
				state_q == mbc_pkg::F_WR) begin
				k_q <= k_q + 2'd1;
			end
			if (start && state_q == mbc_pkg::F_IDLE) begin
				bq_q <= '0;
				xo_q <= '0;
			end else if (state_q == mbc_pkg::F_WR && k_q == 2'd3) begin
				bq_q <= bq_q + 2'd1;
				if (bq_q == 2'd3) begin
					xo_q <= xo_q + 2'd1;
				end
			end
			if (wen) begin
				hvld_q[haddr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ren) begin
			rv_s1   <= hvld_q[haddr];
			rd_k_s1 <= k_q;
		end
		if (rd_vld_s1) begin
			hist_q[rd_k_s1] <= rv_s1 ? $signed(rdata) : 32'sd0;
		end
		if (start && state_q == mbc_pkg::F_IDLE) begin
			carry_q <= x_in;
		end
		unique case (state_q)
			mbc_pkg::F_MUL: begin
				prod_s1 <= prod;
				if (k_q == 2'd1) begin
					acc_q <= 54'(prod_s1);
				end else if (k_q == 2'd2) begin
					acc_q <= acc_q - 54'(prod_s1);
				end
			end
			mbc_pkg::F_ACC: acc_q <= acc_q - 54'(prod_s1) + 54'sd8192;
			mbc_pkg::F_WR: begin
				if (k_q == 2'd0) begin
					y_q <= ysat;
				end
				if (k_q == 2'd3 && bq_q == 2'd1) begin
					bands_q[xo_q] <= y_q;
				end
				if (k_q == 2'd3 && bq_q == 2'd3) begin
					carry_q <= y_q;
				end
			end
			mbc_pkg::F_DONE: bands_q[mbc_pkg::NumBands-1] <= carry_q;
			default: begin
			end
		endcase
	end

	assign bands = bands_q;

endmodule

/* sv/mbc_band.sv */
module mbc_band (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [31:0]  band,
	input  logic signed [15:0]  env_in,
	input  mbc_pkg::band_cfg_t  cfg,
	output mbc_pkg::band_res_t  res
);

	mbc_pkg::band_state_t state_q, state_d;
	logic signed [31:0] band_q;
	logic [31:0]        a_q;
	logic [4:0]         e_q;
	logic [30:0]        m_q;
	logic [15:0]        frac_q;
	logic [3:0]         cnt_q;
	logic [61:0]        sq_s1;
	logic signed [40:0] lprod_s1;
	logic signed [15:0] lvl_q, env_q, gr_q;
	logic signed [33:0] eprod_s1, gprod_s1;
	logic               over_q;
	logic signed [31:0] xprod_s1;
	logic signed [7:0]  n_q;
	logic [15:0]        f_q;
	logic [24:0]        iprod_s1;
	logic [16:0]        mant_q;
	logic signed [49:0] pprod_s1;
	logic signed [47:0] contrib_q;

	logic [31:0]        m2;
	logic signed [5:0]  eoff;
	logic signed [21:0] lval;
	logic signed [40:0] lr;
	logic signed [16:0] ediff, gdiff, tsum;
	logic [15:0]        ecoef;
	logic signed [33:0] er, esum, gr_r, gr_n;
	logic signed [31:0] ev;
	logic [16:0]        tab_lo, tab_hi, tab_d;
	logic signed [8:0]  s9, ns9;
	logic [5:0]         sh;
	logic signed [63:0] p64, pw, lim;
	logic signed [47:0] contrib_d;

	function automatic logic signed [15:0] sat16(input logic signed [40:0] v);
		logic signed [15:0] r;
		if (v > 41'sd32767) begin
			r = 16'sh7FFF;
		end else if (v < -41'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	assign m2     = sq_s1[61:30];
	assign eoff   = $signed({1'b0, e_q}) - 6'sd23 + 6'(24 - mbc_pkg::SampleBits);
	assign lval   = {eoff, frac_q};
	assign lr     = (lprod_s1 + 41'sd8388608) >>> 24;
	assign ediff  = 17'(env_in) - 17'(lvl_q);
	assign ecoef  = (lvl_q > env_in) ? cfg.att : cfg.rel;
	assign er     = (eprod_s1 + 34'sd32768) >>> 16;
	assign esum   = 34'(lvl_q) + er;
	assign gdiff  = 17'(env_q) - 17'(cfg.th);
	assign gr_r   = (gprod_s1 + 34'sd32768) >>> 16;
	assign gr_n   = -gr_r;
	assign tsum   = 17'(gr_q) + 17'(cfg.makeup);
	assign ev     = (xprod_s1 + 32'sd128) >>> 8;
	assign tab_lo = mbc_pkg::exp2_tab({1'b0, f_q[15:12]});
	assign tab_hi = mbc_pkg::exp2_tab({1'b0, f_q[15:12]} + 5'd1);
	assign tab_d  = tab_hi - tab_lo;
	assign ns9    = -9'(n_q);
	assign s9     = 9'sd15 + ns9;
	assign p64    = 64'(pprod_s1);

	always_comb begin
		sh        = '0;
		pw        = '0;
		lim       = '0;
		contrib_d = '0;
		if (s9 > 9'sd0) begin
			sh = (s9 > 9'sd62) ? 6'd62 : s9[5:0];
			pw = (p64 + (64'sd1 <<< (sh - 6'd1))) >>> sh;
			contrib_d = pw[47:0];
		end else begin
			sh  = (-s9 > 9'sd40) ? 6'd40 : 6'(-s9);
			lim = 64'sd1 <<< (6'd40 - sh);
			if (p64 > lim) begin
				contrib_d = 48'sd1 <<< 40;
			end else if (p64 < -lim) begin
				contrib_d = -(48'sd1 <<< 40);
			end else begin
				pw = p64 <<< sh;
				contrib_d = pw[47:0];
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mbc_pkg::B_IDLE: begin
				if (start) begin
					state_d = (band == 32'sd0) ? mbc_pkg::B_ENV : mbc_pkg::B_NORM;
				end
			end
			mbc_pkg::B_NORM: if (a_q[31]) state_d = mbc_pkg::B_SQ;
			mbc_pkg::B_SQ:   state_d = mbc_pkg::B_SQ2;
			mbc_pkg::B_SQ2:  state_d = (cnt_q == 4'd15) ? mbc_pkg::B_LOG : mbc_pkg::B_SQ;
			mbc_pkg::B_LOG:  state_d = mbc_pkg::B_LVL;
			mbc_pkg::B_LVL:  state_d = mbc_pkg::B_ENV;
			mbc_pkg::B_ENV:  state_d = mbc_pkg::B_ENV2;
			mbc_pkg::B_ENV2: state_d = mbc_pkg::B_GR;
			mbc_pkg::B_GR:   state_d = mbc_pkg::B_GR2;
			mbc_pkg::B_GR2:  state_d = mbc_pkg::B_EXP;
			mbc_pkg::B_EXP:  state_d = mbc_pkg::B_EXP2;
			mbc_pkg::B_EXP2: state_d = mbc_pkg::B_INT;
			mbc_pkg::B_INT:  state_d = mbc_pkg::B_MANT;
			mbc_pkg::B_MANT: state_d = mbc_pkg::B_MUL;
			mbc_pkg::B_MUL:  state_d = mbc_pkg::B_SHF;
			mbc_pkg::B_SHF:  state_d = mbc_pkg::B_DONE;
			mbc_pkg::B_DONE: state_d = mbc_pkg::B_IDLE;
			default:         state_d = mbc_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		res.done    = 1'b0;
		res.env     = env_q;
		res.gr      = gr_q;
		res.contrib = contrib_q;
		unique case (state_q)
			mbc_pkg::B_DONE: res.done = 1'b1;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mbc_pkg::B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			mbc_pkg::B_IDLE: begin
				band_q <= band;
				a_q    <= band[31] ? 32'(-band) : 32'(band);
				e_q    <= 5'd31;
				lvl_q  <= mbc_pkg::LevelFloor;
			end
			mbc_pkg::B_NORM: begin
				if (!a_q[31]) begin
					a_q <= a_q << 1;
					e_q <= e_q - 5'd1;
				end else begin
					m_q    <= a_q[31:1];
					frac_q <= '0;
					cnt_q  <= '0;
				end
			end
			mbc_pkg::B_SQ: sq_s1 <= m_q * m_q;
			mbc_pkg::B_SQ2: begin
				cnt_q <= cnt_q + 4'd1;
				if (m2[31]) begin
					frac_q <= {frac_q[14:0], 1'b1};
					m_q    <= m2[31:1];
				end else begin
					frac_q <= {frac_q[14:0], 1'b0};
					m_q    <= m2[30:0];
				end
			end
			mbc_pkg::B_LOG:  lprod_s1 <= lval * $signed({1'b0, mbc_pkg::DbPerOct});
			mbc_pkg::B_LVL:  lvl_q <= sat16(lr);
			mbc_pkg::B_ENV:  eprod_s1 <= $signed({1'b0, ecoef}) * ediff;
			mbc_pkg::B_ENV2: env_q <= sat16(41'(esum));
			mbc_pkg::B_GR: begin
				over_q   <= env_q > cfg.th;
				gprod_s1 <= gdiff * $signed({1'b0, cfg.slope});
			end
			mbc_pkg::B_GR2: begin
				if (!over_q) begin
					gr_q <= '0;
				end else if (gr_n < -34'sd32768) begin
					gr_q <= 16'sh8000;
				end else begin
					gr_q <= gr_n[15:0];
				end
			end
			mbc_pkg::B_EXP:  xprod_s1 <= 32'(tsum) * $signed(32'(mbc_pkg::OctPerDb));
			mbc_pkg::B_EXP2: begin
				n_q <= ev[23:16];
				f_q <= ev[15:0];
			end
			mbc_pkg::B_INT:  iprod_s1 <= tab_d[12:0] * f_q[11:0];
			mbc_pkg::B_MANT: mant_q <= tab_lo + 17'((26'(iprod_s1) + 26'd2048) >> 12);
			mbc_pkg::B_MUL:  pprod_s1 <= band_q * $signed({1'b0, mant_q});
			mbc_pkg::B_SHF:  contrib_q <= contrib_d;
			default: begin
			end
		endcase
	end

endmodule

/* sv/multiband_audio_compressor.sv */
// The crossovers run their biquads one after another on one history memory port and then
// finish. Each band then runs the band unit, which skips normalizing and squaring when
// its signal is zero, else does up to 32 normalize steps and 16 squaring steps, and
// the result is then registered for output.
// Throughput: one item at a time; the next is accepted once the last result is loaded.
// Reset: arst_n clears config registers and history valid flags, envelopes go to -60 dB.
`include "multiband_audio_compressor_defines.svh"

module multiband_audio_compressor (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// sample_in
	input  logic [mbc_pkg::InW-1:0]   s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// sample_out, reduction_band0..3, level_band0..3
	output logic [mbc_pkg::OutW-1:0]  m_tdata,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [5:0]                paddr,
	input  logic [63:0]               pwdata,
	output logic [63:0]               prdata,
	output logic                      pready
);

	localparam logic signed [49:0] SumMax = (50'sd1 <<< (mbc_pkg::SampleBits - 1)) - 50'sd1;
	localparam logic signed [49:0] SumMin = -(50'sd1 <<< (mbc_pkg::SampleBits - 1));

	mbc_pkg::top_state_t state_q, state_d;
	logic [63:0]        cfg_q [mbc_pkg::NumRegs];
	logic signed [15:0] env_q [mbc_pkg::NumBands];
	logic signed [15:0] red_q [mbc_pkg::NumBands];
	logic [1:0]         bi_q;
	logic signed [49:0] sum_q;
	logic               m_tvalid_q;
	logic [mbc_pkg::OutW-1:0] out_q;

	logic               accept, flt_start, flt_done, band_start, load;
	logic signed [31:0] x_in;
	logic [63:0]        xo_coef [mbc_pkg::NumXo];
	logic signed [31:0] bands [mbc_pkg::NumBands];
	mbc_pkg::band_cfg_t band_cfg;
	mbc_pkg::band_res_t band_res;
	logic signed [mbc_pkg::SampleBits-1:0] sample_sat;
	logic [mbc_pkg::OutW-1:0] out_d;

	assign pready = 1'b1;
	assign prdata = cfg_q[paddr[5:3]];
	assign accept = s_tvalid && s_tready;
	assign x_in   = 32'($signed(s_tdata[mbc_pkg::SampleBits-1:0]));
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q;

	for (genvar i = 0; i < mbc_pkg::NumXo; i++) begin : g_xo
		assign xo_coef[i] = cfg_q[int'(mbc_pkg::REG_XO_LOW) + i];
	end

	assign band_cfg.th     = cfg_q[mbc_pkg::REG_THRESH][16*bi_q +: 16];
	assign band_cfg.slope  = cfg_q[mbc_pkg::REG_SLOPE][16*bi_q +: 16];
	assign band_cfg.att    = cfg_q[mbc_pkg::REG_ATTACK][16*bi_q +: 16];
	assign band_cfg.rel    = cfg_q[mbc_pkg::REG_RELEASE][16*bi_q +: 16];
	assign band_cfg.makeup = cfg_q[mbc_pkg::REG_MAKEUP][16*bi_q +: 16];

	mbc_filter u_filter (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (flt_start),
		.x_in   (x_in),
		.xo_coef(xo_coef),
		.done   (flt_done),
		.bands  (bands)
	);

	mbc_band u_band (
		.clk   (clk),
		.arst_n(arst_n),
		.start (band_start),
		.band  (bands[bi_q]),
		.env_in(env_q[bi_q]),
		.cfg   (band_cfg),
		.res   (band_res)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mbc_pkg::T_IDLE:  if (accept) state_d = mbc_pkg::T_FILT;
			mbc_pkg::T_FILT:  if (flt_done) state_d = mbc_pkg::T_BAND;
			mbc_pkg::T_BAND:  state_d = mbc_pkg::T_BWAIT;
			mbc_pkg::T_BWAIT: begin
				if (band_res.done) begin
					state_d = (32'(bi_q) == mbc_pkg::NumBands - 1) ?
						mbc_pkg::T_FIN : mbc_pkg::T_BAND;
				end
			end
			mbc_pkg::T_FIN:   if (!m_tvalid_q || m_tready) state_d = mbc_pkg::T_IDLE;
			default:          state_d = mbc_pkg::T_IDLE;
		endcase
	end

	always_comb begin
		s_tready   = 1'b0;
		band_start = 1'b0;
		load       = 1'b0;
		unique case (state_q)
			mbc_pkg::T_IDLE: s_tready = 1'b1;
			mbc_pkg::T_BAND: band_start = 1'b1;
			mbc_pkg::T_FIN:  load = !m_tvalid_q || m_tready;
			default: begin
			end
		endcase
		flt_start = accept;
	end

	always_comb begin
		if (sum_q > SumMax) begin
			sample_sat = SumMax[mbc_pkg::SampleBits-1:0];
		end else if (sum_q < SumMin) begin
			sample_sat = SumMin[mbc_pkg::SampleBits-1:0];
		end else begin
			sample_sat = sum_q[mbc_pkg::SampleBits-1:0];
		end
		out_d = '0;
		out_d[mbc_pkg::SampleBits-1:0] = sample_sat;
		for (int i = 0; i < 4; i++) begin
			if (i < mbc_pkg::NumBands) begin
				out_d[mbc_pkg::SampleBits + 16*i +: 16]      = red_q[i];
				out_d[mbc_pkg::SampleBits + 64 + 16*i +: 16] = env_q[i];
			end else begin
				out_d[mbc_pkg::SampleBits + 64 + 16*i +: 16] = mbc_pkg::EnvReset;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= mbc_pkg::T_IDLE;
			m_tvalid_q <= 1'b0;
			bi_q       <= '0;
			for (int i = 0; i < mbc_pkg::NumRegs; i++) begin
				cfg_q[i] <= '0;
			end
			for (int i = 0; i < mbc_pkg::NumBands; i++) begin
				env_q[i] <= mbc_pkg::EnvReset;
				red_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (psel && penable && pwrite && pready) begin
				cfg_q[paddr[5:3]] <= pwdata;
			end
			if (load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (flt_done) begin
				bi_q <= '0;
			end else if (state_q == mbc_pkg::T_BWAIT && band_res.done) begin
				env_q[bi_q] <= band_res.env;
				red_q[bi_q] <= band_res.gr;
				bi_q        <= bi_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (flt_done) begin
			sum_q <= '0;
		end else if (state_q == mbc_pkg::T_BWAIT && band_res.done) begin
			sum_q <= sum_q + 50'(band_res.contrib);
		end
		if (load) begin
			out_q <= out_d;
		end
	end

	`MBC_ASSERT_NXT(a_accept_starts_filter, s_tvalid && s_tready, state_q == mbc_pkg::T_FILT, "accepted item did not start the filter")
	`MBC_ASSERT_IMP(a_filter_done_in_filt, flt_done, state_q == mbc_pkg::T_FILT, "filter finished outside the filter phase")
	`MBC_ASSERT_IMP(a_band_done_in_wait, band_res.done, state_q == mbc_pkg::T_BWAIT, "band unit finished while not awaited")
	`MBC_ASSERT_IMP(a_reduction_not_positive, band_res.done, band_res.gr <= 16'sd0, "gain reduction is positive")

endmodule

/* sim/multiband_audio_compressor_tb.sv */
module multiband_audio_compressor_tb;

	typedef enum logic [1:0] {K_SAMPLE, K_WRITE, K_DRAIN} job_kind_t;

	typedef struct {
		job_kind_t          kind;
		mbc_pkg::reg_idx_t  idx;
		logic [63:0]        data;
	} job_t;

	typedef struct {
		logic [23:0] sample;
		logic [15:0] red[4];
		logic [15:0] lvl[4];
	} mix_out_t;

	localparam int SETTLE = 700;
	localparam longint EXP2_LUT[17] = '{32768, 34219, 35734, 37316, 38968, 40693, 42495,
		44376, 46341, 48393, 50535, 52773, 55109, 57549, 60097, 62757, 65536};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [mbc_pkg::InW-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [mbc_pkg::OutW-1:0] m_tdata;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [5:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;

	multiband_audio_compressor dut (.*);

	job_t pending[$];
	mix_out_t expected_mix[$];
	int errors = 0;
	longint cyc = 0;

	logic [63:0] shadow_regs[8];
	int hist[48];
	logic signed [15:0] env_q[4];

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) cyc <= cyc + 1;

	function automatic bit calm();
		return cyc >= 100000 && cyc < 250000;
	endfunction

	function automatic bit idle_now();
		return !calm() && $urandom_range(0, 99) < 15;
	endfunction

	function automatic longint rshr(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint s16(logic [63:0] r, int k);
		logic signed [15:0] t;
		t = r[16*k +: 16];
		return t;
	endfunction

	function automatic longint u16(logic [63:0] r, int k);
		return longint'(r[16*k +: 16]);
	endfunction

	function automatic longint biquad(longint x, longint g, longint two, longint a1,
			longint a2, int b);
		longint acc, y;
		acc = g * (x + two * hist[b] + hist[b+1]) - a1 * hist[b+2] - a2 * hist[b+3];
		y = clamp(rshr(acc, 14), -64'sd2147483648, 64'sd2147483647);
		hist[b+1] = hist[b];
		hist[b] = int'(x);
		hist[b+3] = hist[b+2];
		hist[b+2] = int'(y);
		return y;
	endfunction

	function automatic longint level_db(longint v);
		bit [63:0] a, m;
		int e;
		longint frac, l;
		a = v < 0 ? -v : v;
		frac = 0;
		if (a == 0) return -28253;
		e = 0;
		while (e < 63 && (a >> (e + 1)) != 0) e++;
		m = e <= 30 ? a << (30 - e) : a >> (e - 30);
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= 64'd2147483648) begin
				frac = frac | 1;
				m = m >> 1;
			end
		end
		l = longint'(e - 23) * 65536 + frac;
		return clamp(rshr(l * 217727, 24), -32768, 32767);
	endfunction

	function automatic longint weighted(longint band, longint gain_db);
		longint e, n, f, r, mant, p, s, lim;
		int idx, ls;
		e = rshr(gain_db * 10885, 8);
		n = e >>> 16;
		f = e - n * 65536;
		idx = int'((f >> 12) & 15);
		r = f & 4095;
		mant = EXP2_LUT[idx] + (((EXP2_LUT[idx+1] - EXP2_LUT[idx]) * r + 2048) >>> 12);
		p = band * mant;
		s = 15 - n;
		if (s > 0) return rshr(p, s > 62 ? 62 : int'(s));
		ls = -s > 40 ? 40 : int'(-s);
		lim = (64'sd1 <<< 40) >>> ls;
		if (p > lim) return 64'sd1 <<< 40;
		if (p < -lim) return -(64'sd1 <<< 40);
		return p <<< ls;
	endfunction

	function automatic mix_out_t compress(logic [23:0] raw);
		mix_out_t res;
		longint carry, lp, hp, lvl, env, coef, th, gr, sum;
		longint bands[4];
		logic [63:0] xo;
		logic signed [23:0] sx;
		sx = raw;
		carry = sx;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			xo = shadow_regs[mbc_pkg::REG_XO_LOW + i];
			lp = biquad(biquad(carry, s16(xo, 0), 2, s16(xo, 2), s16(xo, 3), i*16),
				s16(xo, 0), 2, s16(xo, 2), s16(xo, 3), i*16 + 4);
			hp = biquad(biquad(carry, s16(xo, 1), -2, s16(xo, 2), s16(xo, 3), i*16 + 8),
				s16(xo, 1), -2, s16(xo, 2), s16(xo, 3), i*16 + 12);
			bands[i] = lp;
			carry = hp;
		end
		bands[3] = carry;
		for (int i = 0; i < 4; i++) begin
			lvl = level_db(bands[i]);
			env = env_q[i];
			coef = u16(lvl > env ? shadow_regs[mbc_pkg::REG_ATTACK] :
				shadow_regs[mbc_pkg::REG_RELEASE], i);
			th = s16(shadow_regs[mbc_pkg::REG_THRESH], i);
			gr = 0;
			env = clamp(lvl + rshr(coef * (env - lvl), 16), -32768, 32767);
			env_q[i] = env;
			if (env > th)
				gr = clamp(-rshr((env - th) * u16(shadow_regs[mbc_pkg::REG_SLOPE], i), 16),
					-32768, 0);
			res.red[i] = gr[15:0];
			res.lvl[i] = env[15:0];
			sum += weighted(bands[i], gr + s16(shadow_regs[mbc_pkg::REG_MAKEUP], i));
		end
		sum = clamp(sum, -8388608, 8388607);
		res.sample = sum[23:0];
		return res;
	endfunction

	task automatic flag(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got 0x%0h expected 0x%0h at cycle %0d", what, got, want, cyc);
		errors++;
	endtask

	// Sender: samples, register writes and drain pauses, in queue order.
	job_t cur;
	bit busy = 0;
	int apb_step = 0;
	int quiet = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid) begin
				if (s_tready) begin
					expected_mix.push_back(compress(s_tdata[23:0]));
					s_tvalid <= 1'b0;
					busy = 0;
				end
			end else if (busy && cur.kind == K_WRITE) begin
				if (apb_step == 0) begin
					penable <= 1'b1;
					apb_step = 1;
				end else begin
					shadow_regs[cur.idx] = cur.data;
					psel <= 1'b0;
					penable <= 1'b0;
					pwrite <= 1'b0;
					busy = 0;
				end
			end else if (busy && cur.kind == K_DRAIN) begin
				quiet = expected_mix.size() == 0 ? quiet + 1 : 0;
				if (quiet >= SETTLE) busy = 0;
			end else if (!busy && pending.size() > 0) begin
				if (pending[0].kind != K_SAMPLE || !idle_now()) begin
					cur = pending.pop_front();
					busy = 1;
					case (cur.kind)
						K_SAMPLE: begin
							s_tdata <= cur.data[mbc_pkg::InW-1:0];
							s_tvalid <= 1'b1;
						end
						K_WRITE: begin
							psel <= 1'b1;
							pwrite <= 1'b1;
							paddr <= {cur.idx, 3'b000};
							pwdata <= cur.data;
							apb_step = 0;
						end
						default: quiet = 0;
					endcase
				end
			end
		end
	end

	always @(posedge clk) begin
		mix_out_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_mix.size() == 0) begin
					flag("unexpected item", m_tdata[31:0], 32'd0);
				end else begin
					want = expected_mix.pop_front();
					if (m_tdata[23:0] !== want.sample)
						flag("sample_out", m_tdata[23:0], want.sample);
					for (int i = 0; i < 4; i++) begin
						if (m_tdata[24 + 16*i +: 16] !== want.red[i])
							flag($sformatf("reduction_band%0d", i), m_tdata[24 + 16*i +: 16],
								want.red[i]);
						if (m_tdata[88 + 16*i +: 16] !== want.lvl[i])
							flag($sformatf("level_band%0d", i), m_tdata[88 + 16*i +: 16],
								want.lvl[i]);
					end
				end
			end
			m_tready <= !idle_now();
		end
	end

	task automatic add_sample(logic [23:0] v);
		job_t j;
		j.kind = K_SAMPLE;
		j.idx = mbc_pkg::REG_THRESH;
		j.data = {40'd0, v};
		pending.push_back(j);
	endtask

	task automatic add_write(mbc_pkg::reg_idx_t idx, logic [63:0] v);
		job_t j;
		j.kind = K_WRITE;
		j.idx = idx;
		j.data = v;
		pending.push_back(j);
	endtask

	task automatic add_drain();
		job_t j;
		j.kind = K_DRAIN;
		j.idx = mbc_pkg::REG_THRESH;
		j.data = '0;
		pending.push_back(j);
	endtask

	function automatic logic [63:0] pack4(logic [15:0] a, logic [15:0] b, logic [15:0] c,
			logic [15:0] d);
		return {d, c, b, a};
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [15:0] neg16(int v);
		return 16'(-v);
	endfunction

	task automatic plausible_setup();
		logic [15:0] t[4], sl[4], at[4], rl[4], mk[4];
		for (int i = 0; i < 4; i++) begin
			t[i] = neg16($urandom_range(0, 50) * 256);
			sl[i] = 16'($urandom_range(0, 65535));
			at[i] = 16'($urandom_range(30000, 65535));
			rl[i] = 16'($urandom_range(50000, 65535));
			mk[i] = 16'($urandom_range(0, 3072));
		end
		add_write(mbc_pkg::REG_THRESH, pack4(t[0], t[1], t[2], t[3]));
		add_write(mbc_pkg::REG_SLOPE, pack4(sl[0], sl[1], sl[2], sl[3]));
		add_write(mbc_pkg::REG_ATTACK, pack4(at[0], at[1], at[2], at[3]));
		add_write(mbc_pkg::REG_RELEASE, pack4(rl[0], rl[1], rl[2], rl[3]));
		add_write(mbc_pkg::REG_MAKEUP, pack4(mk[0], mk[1], mk[2], mk[3]));
		for (int x = 0; x < 3; x++)
			add_write(mbc_pkg::reg_idx_t'(mbc_pkg::REG_XO_LOW + x),
				pack4(16'($urandom_range(20, 2000)),
				16'($urandom_range(9000, 16000)), neg16($urandom_range(18000, 30000)),
				16'($urandom_range(6000, 13000))));
	endtask

	task automatic fill_setup(int style);
		for (int r = 0; r < 8; r++) begin
			case (style)
				1: add_write(mbc_pkg::reg_idx_t'(r), '1);
				2: add_write(mbc_pkg::reg_idx_t'(r), '0);
				3: add_write(mbc_pkg::reg_idx_t'(r), rand64());
				default: add_write(mbc_pkg::reg_idx_t'(r),
					(r == mbc_pkg::REG_THRESH) ? {4{16'h8000}} :
					(r == mbc_pkg::REG_MAKEUP) ? {4{16'h7fff}} :
					(r >= mbc_pkg::REG_XO_LOW) ? {16'h7fff, 16'h8000, 16'h7fff, 16'h7fff} :
					'1);
			endcase
		end
	endtask

	task automatic random_samples(int count);
		int sel;
		for (int k = 0; k < count; k++) begin
			sel = $urandom_range(0, 9);
			if (sel < 6) add_sample(24'($urandom()));
			else if (sel < 9) add_sample(24'($signed($urandom_range(0, 4000)) - 2000));
			else add_sample($urandom_range(0, 1) ? 24'h7fffff : 24'h800000);
		end
	endtask

	initial begin
		for (int r = 0; r < 8; r++) shadow_regs[r] = '0;
		for (int i = 0; i < 48; i++) hist[i] = 0;
		for (int i = 0; i < 4; i++) env_q[i] = mbc_pkg::EnvReset;

		add_sample(24'h123456);
		add_sample(24'h800000);
		add_sample(24'h7fffff);
		add_drain();
		plausible_setup();
		add_sample(24'h000000);
		add_sample(24'h7fffff);
		add_sample(24'h800000);
		add_sample(24'h000001);
		add_sample(24'hffffff);
		add_sample(24'h000000);
		for (int k = 0; k < 6; k++) add_sample(k[0] ? 24'h800000 : 24'h7fffff);
		add_sample(24'h555555);
		add_sample(24'haaaaaa);
		add_sample(24'h000000);
		add_sample(24'h000000);
		add_drain();
		fill_setup(0);
		add_sample(24'h7fffff);
		add_sample(24'h800000);
		add_sample(24'h000100);

		for (int ph = 0; ph < 7; ph++) begin
			add_drain();
			if (ph == 0 || ph == 3 || ph == 6) plausible_setup();
			else fill_setup(ph == 1 ? 1 : ph == 2 ? 2 : ph == 4 ? 3 : 0);
			random_samples(ph < 2 ? 150 : 270);
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending.size() == 0 && !busy);
		wait (expected_mix.size() == 0);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0 && expected_mix.size() == 0)
			$display("PASS multiband_audio_compressor");
		else
			$display("FAIL multiband_audio_compressor");
		$finish;
	end

	initial begin
		#160000000;
		$display("FAIL multiband_audio_compressor");
		$finish;
	end

endmodule
